/* rtl/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// Types and constants shared by the sliding-window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int WindowMax  = 64;
    localparam int SampleBits = 16;
    localparam int CountBits  = $clog2(WindowMax + 1);

    typedef struct packed {
        logic                          op;
        logic signed [SampleBits-1:0]  sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SampleBits:0]    median_doubled;
        logic                          median_valid;
        logic [CountBits-1:0]          present_count;
    } t_out_item;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_GAP    = 1'b1;

    localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVICT_RD,
        ST_EVICT,
        ST_PUSH,
        ST_MEDIAN,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic ring_read;
        logic evict;
        logic push;
        logic median;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic must_evict;
    } t_status;

endpackage

/* rtl/sliding_window_median.sv */
// ----------------------------------------------------------------------------
// sliding_window_median
// Running median over a window of sample or gap slots, reporting twice the
// median and the number of values present.
//
//   channel | direction | handshake          | payload
//   in      | input     | i_in_valid/o_in_stall   | t_in_item
//   out     | output    | o_out_valid/i_out_stall | t_out_item
//   cfg     | input     | APB                | window_length at 0x0
//
// An item passes ST_IDLE, ST_EVICT_RD, an ST_EVICT/ST_EVICT_RD pair per evicted slot
// (the slot ring read is registered), ST_PUSH, ST_MEDIAN, and ST_OUT, held under stall.
// Reset is synchronous, active low; the window starts empty at full length.
// ----------------------------------------------------------------------------
module sliding_window_median (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  swm_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output swm_pkg::t_out_item   o_out_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import swm_pkg::*;

    localparam int CW = CountBits;

    logic [CW-1:0] r_window_length;
    logic [CW-1:0] wr_val;
    t_cmd          cmd;
    t_status       status;
    logic signed [SampleBits:0] med;
    logic          med_valid;
    logic [CW-1:0] cnt;

    assign pready = 1'b1;
    assign wr_val = pwdata[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= CW'(WindowMax);
        end else if (psel && penable && pwrite && paddr[2] == REG_WINDOW_LENGTH) begin
            if (wr_val == '0) r_window_length <= CW'(1);
            else if (32'(wr_val) > 32'(WindowMax)) r_window_length <= CW'(WindowMax);
            else r_window_length <= wr_val;
        end
    end

    assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ? 32'(r_window_length) : '0;

    swm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    swm_datapath #(
        .WINDOW_MAX  (WindowMax),
        .SAMPLE_BITS (SampleBits)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_window_length  (r_window_length),
        .i_gap            (i_in_item.op == OP_GAP),
        .i_sample         (i_in_item.sample),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_median_doubled (med),
        .o_median_valid   (med_valid),
        .o_present_count  (cnt)
    );

    assign o_out_item.median_doubled = med;
    assign o_out_item.median_valid   = med_valid;
    assign o_out_item.present_count  = cnt;
endmodule

/* rtl/swm_datapath.sv */
// ----------------------------------------------------------------------------
// swm_datapath
// Slot ring memory, sorted cell array and median arithmetic.
// ----------------------------------------------------------------------------
module swm_datapath #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int CW          = $clog2(WINDOW_MAX + 1),
    parameter int AW          = $clog2(WINDOW_MAX)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [CW-1:0]                 i_window_length,
    input  logic                          i_gap,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  swm_pkg::t_cmd                 i_cmd,
    output swm_pkg::t_status              o_status,
    output logic signed [SAMPLE_BITS:0]   o_median_doubled,
    output logic                          o_median_valid,
    output logic [CW-1:0]                 o_present_count
);
    import swm_pkg::*;

    logic [SAMPLE_BITS:0]           r_ring [WINDOW_MAX];
    logic [SAMPLE_BITS:0]           r_ring_q;
    logic signed [SAMPLE_BITS-1:0]  r_cells [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0]  n_cells [WINDOW_MAX];
    logic [CW-1:0]                  r_slot_count, r_value_count, n_value_count;
    logic [AW-1:0]                  r_head;
    logic                           r_gap;
    logic signed [SAMPLE_BITS-1:0]  r_sample;
    logic signed [SAMPLE_BITS:0]    r_med;
    logic [AW:0]                    tail_sum;
    logic [AW-1:0]                  tail;
    logic [CW-1:0]                  h;
    logic [AW-1:0]                  h_idx, hm_idx;
    logic                           ev_present;
    logic signed [SAMPLE_BITS-1:0]  ev_val;
    logic [WINDOW_MAX-1:0]          eq, le, rm_seen;

    assign o_status.must_evict = (r_slot_count >= i_window_length) && (r_slot_count != '0);

    assign tail_sum = {1'b0, r_head} + AW'(r_slot_count) + ((r_slot_count[CW-1]
                      && CW > AW) ? (AW+1)'(WINDOW_MAX) : '0);
    assign tail     = (tail_sum >= (AW+1)'(WINDOW_MAX)) ?
                      AW'(tail_sum - (AW+1)'(WINDOW_MAX)) : AW'(tail_sum);

    assign ev_present = r_ring_q[SAMPLE_BITS];
    assign ev_val     = r_ring_q[SAMPLE_BITS-1:0];

    // Removal: cells at and above the first match shift down one place.
    // Insertion: cells above the last one not greater than the sample shift up.
    always_comb begin
        n_cells       = r_cells;
        n_value_count = r_value_count;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            eq[i] = (CW'(i) < r_value_count) && (r_cells[i] == ev_val);
            le[i] = (CW'(i) < r_value_count) && (r_cells[i] <= r_sample);
        end
        rm_seen[0] = eq[0];
        for (int i = 1; i < WINDOW_MAX; i++) rm_seen[i] = rm_seen[i-1] | eq[i];
        if (i_cmd.evict && ev_present && rm_seen[WINDOW_MAX-1]) begin
            for (int i = 0; i < WINDOW_MAX - 1; i++)
                if (rm_seen[i]) n_cells[i] = r_cells[i+1];
            n_value_count = r_value_count - 1'b1;
        end else if (i_cmd.push && !r_gap && r_value_count < CW'(WINDOW_MAX)) begin
            for (int i = 0; i < WINDOW_MAX; i++) begin
                if (!le[i] && CW'(i) <= r_value_count)
                    n_cells[i] = (i == 0 || le[(i == 0) ? 0 : i-1]) ? r_sample
                                 : r_cells[(i == 0) ? 0 : i-1];
            end
            n_value_count = r_value_count + 1'b1;
        end
    end

    assign h      = r_value_count >> 1;
    assign h_idx  = AW'(h);
    assign hm_idx = AW'(h - 1'b1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_gap    <= i_gap;
            r_sample <= i_sample;
        end
        if (i_cmd.ring_read) r_ring_q <= r_ring[r_head];
        if (i_cmd.push) r_ring[tail] <= {!r_gap, r_gap ? {SAMPLE_BITS{1'b0}} : r_sample};
        r_cells <= n_cells;
        if (i_cmd.median) begin
            if (r_value_count == '0) r_med <= '0;
            else if (r_value_count[0]) r_med <= {r_cells[h_idx], 1'b0};
            else r_med <= (SAMPLE_BITS+1)'(r_cells[hm_idx]) +
                          (SAMPLE_BITS+1)'(r_cells[h_idx]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count  <= '0;
            r_value_count <= '0;
            r_head        <= '0;
        end else begin
            r_value_count <= n_value_count;
            if (i_cmd.evict) begin
                r_slot_count <= r_slot_count - 1'b1;
                r_head <= (r_head == AW'(WINDOW_MAX - 1)) ? '0 : r_head + 1'b1;
            end else if (i_cmd.push) begin
                r_slot_count <= r_slot_count + 1'b1;
            end
        end
    end

    assign o_median_doubled = r_med;
    assign o_median_valid   = r_value_count != '0;
    assign o_present_count  = r_value_count;
endmodule

/* rtl/swm_ctrl.sv */
// ----------------------------------------------------------------------------
// swm_ctrl
// Sequencer: evict oldest slots as needed, push, take median, hold result.
// ----------------------------------------------------------------------------
module swm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  swm_pkg::t_status i_status,
    output swm_pkg::t_cmd    o_cmd
);
    import swm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = ST_EVICT_RD;
                end
            end
            ST_EVICT_RD: begin
                if (i_status.must_evict) begin
                    o_cmd.ring_read = 1'b1;
                    n_state = ST_EVICT;
                end else begin
                    n_state = ST_PUSH;
                end
            end
            ST_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state = ST_EVICT_RD;
            end
            ST_PUSH: begin
                o_cmd.push = 1'b1;
                n_state = ST_MEDIAN;
            end
            ST_MEDIAN: begin
                o_cmd.median = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
